### hdl/dvia_pkg.sv
// Package for the dual interface adapter register block.
// Holds operation codes, register indexes, controller states and the shared command struct.
package dvia_pkg;

    localparam int NumAdaptersDefault = 2;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [3:0] REG_ORB   = 4'h0;
    localparam logic [3:0] REG_ORA   = 4'h1;
    localparam logic [3:0] REG_DDRB  = 4'h2;
    localparam logic [3:0] REG_DDRA  = 4'h3;
    localparam logic [3:0] REG_T1CL  = 4'h4;
    localparam logic [3:0] REG_T1CH  = 4'h5;
    localparam logic [3:0] REG_T1LL  = 4'h6;
    localparam logic [3:0] REG_T1LH  = 4'h7;
    localparam logic [3:0] REG_T2CL  = 4'h8;
    localparam logic [3:0] REG_T2CH  = 4'h9;
    localparam logic [3:0] REG_SR    = 4'hA;
    localparam logic [3:0] REG_ACR   = 4'hB;
    localparam logic [3:0] REG_PCR   = 4'hC;
    localparam logic [3:0] REG_IFR   = 4'hD;
    localparam logic [3:0] REG_IER   = 4'hE;
    localparam logic [3:0] REG_ORANH = 4'hF;

    localparam logic [1:0] PSG_NONE  = 2'd0;
    localparam logic [1:0] PSG_RESET = 2'd1;
    localparam logic [1:0] PSG_WRITE = 2'd2;
    localparam logic [1:0] PSG_LATCH = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_DONE = 2'd2
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the request
        logic execute;   // apply the request to the register file
        logic respond;   // drive the result strobe
    } t_cmd;

endpackage

### hdl/dvia_ctrl.sv
// Controller state machine for the dual adapter block.
// Depends on dvia_pkg.
module dvia_ctrl
    import dvia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_EXEC;
            end
            ST_EXEC: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                o_cmd.capture = i_start;
            end
            ST_EXEC: o_cmd.execute = 1'b1;
            ST_DONE: o_cmd.respond = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

    // a request steps from idle through execute to done
    a_exec_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_cmd.execute) else $error("no execute");
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> o_cmd.respond) else $error("no respond");
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("overlapping commands");

endmodule

### hdl/dvia_dp.sv
// Datapath: register file of both adapters, timers, read mux and result register.
// Depends on dvia_pkg.
module dvia_dp
    import dvia_pkg::*;
#(
    parameter int NUM_ADAPTERS = NumAdaptersDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_bus_offset,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_elapsed_clocks,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic        o_read_hit,
    output logic        o_irq,
    output logic [1:0]  o_psg_command,
    output logic [3:0]  o_psg_register,
    output logic [7:0]  o_psg_data,
    output logic        o_timer_fired
);

    // captured request
    logic [1:0]  r_op;
    logic [7:0]  r_off, r_wd;
    logic [15:0] r_clk;

    // adapter state
    logic [7:0]  r_pb [2], r_pa [2], r_db [2], r_da [2];
    logic [15:0] r_t1l [2], r_t1c [2], r_t2l [2], r_t2c [2];
    logic [7:0]  r_acr [2], r_pcr [2], r_ifr [2], r_ier [2];
    logic [3:0]  r_sel [2];
    logic [1:0]  r_run;
    logic        r_armed;

    logic [7:0]  n_pb [2], n_pa [2], n_db [2], n_da [2];
    logic [15:0] n_t1l [2], n_t1c [2], n_t2l [2], n_t2c [2];
    logic [7:0]  n_acr [2], n_pcr [2], n_ifr [2], n_ier [2];
    logic [3:0]  n_sel [2];
    logic [1:0]  n_run;
    logic        n_armed;

    // result register
    logic        r_done;
    logic [7:0]  r_rd, r_pdata;
    logic        r_hit, r_fired;
    logic [1:0]  r_pcmd;
    logic [3:0]  r_preg;
    logic [7:0]  n_rd, n_pdata;
    logic        n_hit, n_fired;
    logic [1:0]  n_pcmd;
    logic [3:0]  n_preg;

    logic        hit, sel;
    logic [3:0]  rg;
    logic [7:0]  v;
    logic [15:0] old1;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_operation;
            r_off <= i_bus_offset;
            r_wd  <= i_write_data;
            r_clk <= i_elapsed_clocks;
        end
    end

    // decode
    always_comb begin
        rg  = r_off[3:0];
        hit = 1'b0;
        sel = 1'b0;
        if (r_off[7:4] == 4'h0) begin
            hit = 1'b1;
        end else if (r_off[7:4] == 4'h8 && NUM_ADAPTERS > 1) begin
            hit = 1'b1;
            sel = 1'b1;
        end
    end

    // execute one request
    always_comb begin
        n_pb = r_pb; n_pa = r_pa; n_db = r_db; n_da = r_da;
        n_t1l = r_t1l; n_t1c = r_t1c; n_t2l = r_t2l; n_t2c = r_t2c;
        n_acr = r_acr; n_pcr = r_pcr; n_ifr = r_ifr; n_ier = r_ier;
        n_sel = r_sel; n_run = r_run; n_armed = r_armed;
        n_rd = '0; n_hit = 1'b0; n_fired = 1'b0;
        n_pcmd = PSG_NONE; n_preg = '0; n_pdata = '0;
        v = '0;
        old1 = '0;
        unique case (t_op'(r_op))
            OP_READ: begin
                if (hit) begin
                    n_hit = 1'b1;
                    unique case (rg)
                        REG_ORB:  n_rd = r_pb[sel];
                        REG_ORA, REG_ORANH: n_rd = r_pa[sel];
                        REG_DDRB: n_rd = r_db[sel];
                        REG_DDRA: n_rd = r_da[sel];
                        REG_T1CL: begin
                            n_rd = r_t1c[sel][7:0];
                            n_ifr[sel][6] = 1'b0;
                        end
                        REG_T1CH: n_rd = r_t1c[sel][15:8];
                        REG_T1LL: n_rd = r_t1l[sel][7:0];
                        REG_T1LH: n_rd = r_t1l[sel][15:8];
                        REG_T2CL: begin
                            n_rd = r_t2c[sel][7:0];
                            n_ifr[sel][5] = 1'b0;
                        end
                        REG_T2CH: n_rd = r_t2c[sel][15:8];
                        REG_ACR:  n_rd = r_acr[sel];
                        REG_PCR:  n_rd = r_pcr[sel];
                        REG_IFR:  n_rd = r_ifr[sel];
                        REG_IER:  n_rd = r_ier[sel] | 8'h80;
                        default:  n_rd = '0;
                    endcase
                end
            end
            OP_WRITE: begin
                if (hit) begin
                    n_hit = 1'b1;
                    unique case (rg)
                        REG_ORB: begin
                            v = r_wd & r_db[sel];
                            n_pb[sel] = v;
                            if (!v[2]) begin
                                n_pcmd = PSG_RESET;
                            end else if (v[1]) begin
                                if (!v[0]) begin
                                    n_pcmd  = PSG_WRITE;
                                    n_preg  = r_sel[sel];
                                    n_pdata = r_pa[sel];
                                end else begin
                                    n_pcmd = PSG_LATCH;
                                    if (r_pa[sel][7:4] == 4'h0) n_sel[sel] = r_pa[sel][3:0];
                                end
                            end
                        end
                        REG_ORA, REG_ORANH: n_pa[sel] = r_wd & r_da[sel];
                        REG_DDRB: n_db[sel] = r_wd;
                        REG_DDRA: n_da[sel] = r_wd;
                        REG_T1CL, REG_T1LL: n_t1l[sel][7:0] = r_wd;
                        REG_T1CH: begin
                            n_ifr[sel][6] = 1'b0;
                            n_t1l[sel][15:8] = r_wd;
                            n_t1c[sel] = {r_wd, r_t1l[sel][7:0]};
                            if (!sel && r_ier[0][6] && r_wd != 8'h00) begin
                                n_run[0] = 1'b1;
                                n_armed  = 1'b1;
                            end
                        end
                        REG_T1LH: begin
                            n_t1l[sel][15:8] = r_wd;
                            n_ifr[sel][6] = 1'b0;
                        end
                        REG_T2CL: n_t2l[sel][7:0] = r_wd;
                        REG_T2CH: begin
                            n_ifr[sel][5] = 1'b0;
                            n_t2l[sel][15:8] = r_wd;
                            n_t2c[sel] = {r_wd, r_t2l[sel][7:0]};
                        end
                        REG_ACR: n_acr[sel] = r_wd;
                        REG_PCR: n_pcr[sel] = r_wd;
                        REG_IFR: n_ifr[sel][6:0] = r_ifr[sel][6:0] & ~r_wd[6:0];
                        REG_IER: begin
                            if (!r_wd[7]) begin
                                n_ier[sel] = r_ier[sel] & ~(r_wd | 8'h80);
                                if (!n_ier[sel][6] && r_run[sel]) begin
                                    n_run[sel] = 1'b0;
                                    n_armed    = 1'b0;
                                end
                            end else begin
                                n_ier[sel][6:0] = r_ier[sel][6:0] | r_wd[6:0];
                                if (!sel && n_ier[0][6] && r_t1l[0][15:8] != 8'h00) begin
                                    n_run[0] = 1'b1;
                                    n_armed  = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_TICK: begin
                for (int a = 0; a < NUM_ADAPTERS; a++) begin
                    n_t1c[a] = r_t1c[a] - r_clk;
                    n_t2c[a] = r_t2c[a] - r_clk;
                end
                old1 = r_t1c[0];
                if (!old1[15] && n_t1c[0][15] && r_armed) begin
                    n_fired = 1'b1;
                    n_ifr[0][6] = 1'b1;
                    if (!r_acr[0][6]) begin
                        n_run[0] = 1'b0;
                        n_armed  = 1'b0;
                    end else begin
                        n_t1c[0] = r_t1l[0];
                        if (r_ier[0][6] && r_t1l[0][15:8] != 8'h00) begin
                            n_run[0] = 1'b1;
                            n_armed  = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        // keep the summary bit consistent
        for (int a = 0; a < 2; a++) begin
            n_ifr[a][7] = |(n_ifr[a][6:0] & n_ier[a][6:0]);
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 2; a++) begin
                r_pb[a] <= '0; r_pa[a] <= '0; r_db[a] <= '0; r_da[a] <= '0;
                r_t1l[a] <= '0; r_t1c[a] <= '0; r_t2l[a] <= '0; r_t2c[a] <= '0;
                r_acr[a] <= '0; r_pcr[a] <= '0; r_ifr[a] <= '0; r_ier[a] <= '0;
                r_sel[a] <= '0;
            end
            r_run   <= '0;
            r_armed <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.execute;
            if (i_cmd.execute) begin
                r_pb <= n_pb; r_pa <= n_pa; r_db <= n_db; r_da <= n_da;
                r_t1l <= n_t1l; r_t1c <= n_t1c; r_t2l <= n_t2l; r_t2c <= n_t2c;
                r_acr <= n_acr; r_pcr <= n_pcr; r_ifr <= n_ifr; r_ier <= n_ier;
                r_sel <= n_sel; r_run <= n_run; r_armed <= n_armed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_rd <= n_rd; r_hit <= n_hit; r_fired <= n_fired;
            r_pcmd <= n_pcmd; r_preg <= n_preg; r_pdata <= n_pdata;
        end
    end

    assign o_done         = r_done & i_cmd.respond;
    assign o_read_data    = r_rd;
    assign o_read_hit     = r_hit;
    assign o_irq          = r_ifr[0][7] | r_ifr[1][7];
    assign o_psg_command  = r_pcmd;
    assign o_psg_register = r_preg;
    assign o_psg_data     = r_pdata;
    assign o_timer_fired  = r_fired;

    // summary bit tracks flags and enables
    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ifr[0][7] == |(r_ifr[0][6:0] & r_ier[0][6:0])) else $error("summary");
    a_fire_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.respond && r_fired) |-> r_ifr[0][6]) else $error("fire flag");
    a_armed_matches_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed == r_run[0]) else $error("armed mismatch");

endmodule

### hdl/dual_via_timer_interrupt_regs.sv
// A request accepted in idle passes through the execute and done states before its result strobe.
// A new request is taken only when idle; busy covers the execute and respond states.
// The register file updates during the execute step of a three-step controller sequence.
// Reset (synchronous, active low) clears every adapter register and the timer state.
// The result strobe lasts one cycle and the receiver cannot stall.
// Top level: joins dvia_ctrl and dvia_dp; depends on dvia_pkg.
module dual_via_timer_interrupt_regs
    import dvia_pkg::*;
#(
    parameter int NUM_ADAPTERS = NumAdaptersDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_bus_offset,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_elapsed_clocks,
    output logic        o_valid,
    output logic [7:0]  o_read_data,
    output logic        o_read_hit,
    output logic        o_irq,
    output logic [1:0]  o_psg_command,
    output logic [3:0]  o_psg_register,
    output logic [7:0]  o_psg_data,
    output logic        o_timer_fired
);

    t_cmd cmd;

    dvia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    dvia_dp #(.NUM_ADAPTERS(NUM_ADAPTERS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_operation      (i_operation),
        .i_bus_offset     (i_bus_offset),
        .i_write_data     (i_write_data),
        .i_elapsed_clocks (i_elapsed_clocks),
        .o_done           (o_valid),
        .o_read_data      (o_read_data),
        .o_read_hit       (o_read_hit),
        .o_irq            (o_irq),
        .o_psg_command    (o_psg_command),
        .o_psg_register   (o_psg_register),
        .o_psg_data       (o_psg_data),
        .o_timer_fired    (o_timer_fired)
    );

endmodule
